// ===== sv/rrs_pkg.sv =====
// ----------------------------------------------------------------------------
// rrs_pkg: shared types and constants of the replica round-robin selector
// Request kinds, field widths, list entry layout and parameter defaults.
// ----------------------------------------------------------------------------
package rrs_pkg;

	// Default sizes
	localparam int unsigned NUM_MODELS_DEF   = 8;
	localparam int unsigned MAX_REPLICAS_DEF = 8;
	localparam int unsigned NUM_UNITS_DEF    = 16;

	// Field widths of the channels
	localparam int unsigned KIND_W   = 3;
	localparam int unsigned MODEL_W  = 3;
	localparam int unsigned UNIT_W   = 4;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned COUNT_W  = 4;
	localparam int unsigned MASK_W   = 16;

	localparam logic [MASK_W-1:0]   MASK_ONE      = MASK_W'(1);
	localparam logic [STATUS_W-1:0] STATUS_AVAIL  = '0;

	// Request kinds
	typedef enum logic [KIND_W-1:0] {
		KIND_ADD    = 3'd0,
		KIND_REMOVE = 3'd1,
		KIND_SET    = 3'd2,
		KIND_GET    = 3'd3,
		KIND_SELECT = 3'd4,
		KIND_QUERY  = 3'd5
	} kind_t;

	// One list entry as held in the entry RAM
	typedef struct packed {
		logic [UNIT_W-1:0]   unit;
		logic [STATUS_W-1:0] status;
	} entry_t;

endpackage

// ===== sv/rrs_req_if.sv =====
// ----------------------------------------------------------------------------
// rrs_req_if: request channel
// Valid/ready handshake carrying one selector request.
// ----------------------------------------------------------------------------
interface rrs_req_if
	import rrs_pkg::*;
;
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [MODEL_W-1:0]  model_id;
	logic [UNIT_W-1:0]   unit_id;
	logic [STATUS_W-1:0] new_status;

	modport source (output valid, kind, model_id, unit_id, new_status, input ready);
	modport sink   (input valid, kind, model_id, unit_id, new_status, output ready);
endinterface

// ===== sv/rrs_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rrs_rsp_if: response channel
// Valid/ready handshake carrying one selector result.
// ----------------------------------------------------------------------------
interface rrs_rsp_if
	import rrs_pkg::*;
;
	logic                valid;
	logic                ready;
	logic                ok;
	logic [UNIT_W-1:0]   chosen_unit;
	logic [STATUS_W-1:0] unit_status;
	logic [COUNT_W-1:0]  unit_count;
	logic [MASK_W-1:0]   avail_mask;

	modport source (output valid, ok, chosen_unit, unit_status, unit_count, avail_mask,
		input ready);
	modport sink   (input valid, ok, chosen_unit, unit_status, unit_count, avail_mask,
		output ready);
endinterface

// ===== sv/rrs_entry_ram.sv =====
// ----------------------------------------------------------------------------
// rrs_entry_ram: replica list storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rrs_entry_ram
	import rrs_pkg::*;
#(
	parameter int unsigned DEPTH = NUM_MODELS_DEF * MAX_REPLICAS_DEF,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  entry_t        wdata,
	input  logic [AW-1:0] raddr,
	output entry_t        rdata
);

	entry_t mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/replica_round_robin_selector.sv =====
// ----------------------------------------------------------------------------
// replica_round_robin_selector: per-model replica lists with round-robin pick
// Adds, removes, updates, reads, queries and selects replica units of each model slot.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request per transaction (kind, model_id, unit_id,
//   new_status); rsp returns exactly one result per request, in order.
//   Each request walks the model's list through one shared RAM read port and
//   one compare unit, one entry per cycle. A remove that closes a gap then
//   moves each entry behind the removed one up by one, and a request for an
//   unknown model slot skips the scan. req.ready is high only while the
//   sequencer is idle, so one request is in work at a time.
//   The result sits in an output register: a new request is taken while a
//   result waits on a stalled receiver, and that request holds in its last
//   step until the register frees.
//   Reset clears all list lengths and pointers, so every list starts empty;
//   the entry RAM needs no clearing since only entries below a list's
//   length are ever read.
// ----------------------------------------------------------------------------
module replica_round_robin_selector
	import rrs_pkg::*;
#(
	parameter int unsigned NUM_MODELS   = NUM_MODELS_DEF,
	parameter int unsigned MAX_REPLICAS = MAX_REPLICAS_DEF,
	parameter int unsigned NUM_UNITS    = NUM_UNITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	rrs_req_if.sink    req,
	rrs_rsp_if.source  rsp
);

	localparam int unsigned DEPTH = NUM_MODELS * MAX_REPLICAS;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned MW    = (NUM_MODELS > 1) ? $clog2(NUM_MODELS) : 1;
	localparam int unsigned CW    = $clog2(MAX_REPLICAS + 1);
	localparam int unsigned IW    = (MAX_REPLICAS > 1) ? $clog2(MAX_REPLICAS) : 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_APPLY,
		S_SHIFT,
		S_FINISH
	} state_t;

	state_t state_q;

	// Per-model list lengths and round-robin pointers
	logic [CW-1:0] len_q [NUM_MODELS];
	logic [IW-1:0] ptr_q [NUM_MODELS];

	// Request in work
	kind_t               kind_q;
	logic                mvalid_q;
	logic [MW-1:0]       midx_q;
	logic [AW-1:0]       base_q;
	logic [UNIT_W-1:0]   unit_q;
	logic [STATUS_W-1:0] st_q;
	logic [CW-1:0]       n_q;

	// Scan sequencer
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] idx_q;
	logic          rd_vld_s1;
	logic [CW-1:0] rd_idx_s1;

	// Scan findings
	logic                found_q;
	logic [CW-1:0]       pos_q;
	logic [STATUS_W-1:0] fstat_q;
	logic                sel_found_q;
	logic [CW-1:0]       sel_idx_q;
	logic [UNIT_W-1:0]   sel_unit_q;
	logic [MASK_W-1:0]   mask_q;

	// Result waiting for the output register
	logic                res_ok_q;
	logic [UNIT_W-1:0]   res_chosen_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [COUNT_W-1:0]  res_count_q;

	// Result worked out from the scan findings
	logic                res_ok_d;
	logic [UNIT_W-1:0]   res_chosen_d;
	logic [STATUS_W-1:0] res_status_d;
	logic [COUNT_W-1:0]  res_count_d;
	logic [MASK_W-1:0]   mask_d;
	logic                shift_go;

	// Output register
	logic                rsp_valid_q;
	logic                rsp_ok_q;
	logic [UNIT_W-1:0]   rsp_chosen_q;
	logic [STATUS_W-1:0] rsp_status_q;
	logic [COUNT_W-1:0]  rsp_count_q;
	logic [MASK_W-1:0]   rsp_mask_q;

	// RAM ports
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	entry_t        ram_wdata;
	logic [AW-1:0] ram_raddr;
	entry_t        ram_rdata;

	logic          accept;
	logic          in_model_ok;
	logic [MW-1:0] in_midx;
	logic          issue;
	logic          add_ok;
	logic          out_free;
	logic [CW-1:0] sel_next;
	logic [CW-1:0] idx_next;
	logic [MASK_W-1:0] unit_bit;

	rrs_entry_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Handshake and decode
	assign req.ready   = (state_q == S_IDLE);
	assign accept      = req.valid && req.ready;
	assign in_model_ok = (int'(req.model_id) < NUM_MODELS);
	assign in_midx     = MW'(req.model_id);
	assign out_free    = !rsp_valid_q || rsp.ready;
	assign unit_bit    = MASK_ONE << unit_q;

	// Issue one list read per cycle while scanning or moving entries
	assign issue = ((state_q == S_SCAN) && (cnt_q != n_q)) ||
		((state_q == S_SHIFT) && (idx_q != n_q));
	assign idx_next  = (idx_q + CW'(1) == n_q) ? '0 : idx_q + CW'(1);
	assign ram_raddr = base_q + AW'(idx_q);

	assign add_ok   = (int'(unit_q) < NUM_UNITS) && (n_q < CW'(MAX_REPLICAS)) && !found_q;
	assign sel_next = (sel_idx_q + CW'(1) == n_q) ? '0 : sel_idx_q + CW'(1);

	// Write port: append, status update, or move an entry up by one
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = base_q + AW'(rd_idx_s1) - AW'(1);
		ram_wdata = ram_rdata;
		case (state_q)
			S_APPLY: begin
				if (mvalid_q && (kind_q == KIND_ADD) && add_ok) begin
					ram_we    = 1'b1;
					ram_waddr = base_q + AW'(n_q);
					ram_wdata = '{unit: unit_q, status: STATUS_AVAIL};
				end else if (mvalid_q && (kind_q == KIND_SET) && found_q) begin
					ram_we    = 1'b1;
					ram_waddr = base_q + AW'(pos_q);
					ram_wdata = '{unit: unit_q, status: st_q};
				end
			end
			S_SHIFT: begin
				ram_we = rd_vld_s1;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// Work out the result and the mask after the request
	always_comb begin
		res_ok_d     = 1'b0;
		res_chosen_d = '0;
		res_status_d = '0;
		res_count_d  = COUNT_W'(n_q);
		mask_d       = mask_q;
		shift_go     = 1'b0;
		if (!mvalid_q) begin
			res_count_d = '0;
			mask_d      = '0;
		end else begin
			case (kind_q)
				KIND_ADD: begin
					if (add_ok) begin
						res_ok_d    = 1'b1;
						res_count_d = COUNT_W'(n_q + CW'(1));
						mask_d      = mask_q | unit_bit;
					end
				end
				KIND_REMOVE: begin
					if (found_q) begin
						res_ok_d    = 1'b1;
						res_count_d = COUNT_W'(n_q - CW'(1));
						mask_d      = mask_q & ~unit_bit;
						// Close the gap behind the removed entry
						shift_go    = (pos_q + CW'(1) != n_q);
					end
				end
				KIND_SET: begin
					if (found_q) begin
						res_ok_d = 1'b1;
						if (st_q == STATUS_AVAIL) begin
							mask_d = mask_q | unit_bit;
						end else begin
							mask_d = mask_q & ~unit_bit;
						end
					end
				end
				KIND_GET: begin
					if (found_q) begin
						res_ok_d     = 1'b1;
						res_status_d = fstat_q;
					end
				end
				KIND_SELECT: begin
					if (sel_found_q) begin
						res_ok_d     = 1'b1;
						res_chosen_d = sel_unit_q;
					end
				end
				KIND_QUERY: begin
					res_ok_d = 1'b1;
				end
				default: begin
					res_ok_d = 1'b0;
				end
			endcase
		end
	end

	// Sequencer, list state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rd_vld_s1   <= 1'b0;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < NUM_MODELS; i++) begin
				len_q[i] <= '0;
				ptr_q[i] <= '0;
			end
		end else begin
			rd_vld_s1 <= issue;
			rd_idx_s1 <= idx_q;
			if (issue) begin
				cnt_q <= cnt_q + CW'(1);
				idx_q <= (state_q == S_SCAN) ? idx_next : idx_q + CW'(1);
			end

			// Drop the result once the receiver takes it
			if (rsp_valid_q && rsp.ready && (state_q != S_FINISH)) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						kind_q      <= kind_t'(req.kind);
						mvalid_q    <= in_model_ok;
						midx_q      <= in_midx;
						base_q      <= AW'(in_midx) * AW'(MAX_REPLICAS);
						unit_q      <= req.unit_id;
						st_q        <= req.new_status;
						n_q         <= in_model_ok ? len_q[in_midx] : '0;
						cnt_q       <= '0;
						idx_q       <= (in_model_ok && (kind_t'(req.kind) == KIND_SELECT)) ?
							CW'(ptr_q[in_midx]) : '0;
						found_q     <= 1'b0;
						sel_found_q <= 1'b0;
						mask_q      <= '0;
						state_q     <= in_model_ok ? S_SCAN : S_APPLY;
					end
				end
				S_SCAN: begin
					// Compare each returned entry against the request
					if (rd_vld_s1) begin
						if (ram_rdata.status == STATUS_AVAIL) begin
							mask_q <= mask_q | (MASK_ONE << ram_rdata.unit);
							if (!sel_found_q) begin
								sel_found_q <= 1'b1;
								sel_idx_q   <= rd_idx_s1;
								sel_unit_q  <= ram_rdata.unit;
							end
						end
						if (ram_rdata.unit == unit_q) begin
							found_q <= 1'b1;
							pos_q   <= rd_idx_s1;
							fstat_q <= ram_rdata.status;
						end
					end else if (cnt_q == n_q) begin
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					res_ok_q     <= res_ok_d;
					res_chosen_q <= res_chosen_d;
					res_status_q <= res_status_d;
					res_count_q  <= res_count_d;
					mask_q       <= mask_d;
					state_q      <= shift_go ? S_SHIFT : S_FINISH;
					if (shift_go) begin
						idx_q <= pos_q + CW'(1);
					end
					// Update the list length and pointer of the model
					if (mvalid_q) begin
						case (kind_q)
							KIND_ADD: begin
								if (add_ok) begin
									len_q[midx_q] <= n_q + CW'(1);
								end
							end
							KIND_REMOVE: begin
								if (found_q) begin
									len_q[midx_q] <= n_q - CW'(1);
									if (CW'(ptr_q[midx_q]) >= n_q - CW'(1)) begin
										ptr_q[midx_q] <= '0;
									end
								end
							end
							KIND_SELECT: begin
								if (sel_found_q) begin
									ptr_q[midx_q] <= IW'(sel_next);
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_SHIFT: begin
					if (!rd_vld_s1 && (idx_q == n_q)) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					// Hold until the output register is free
					if (out_free) begin
						rsp_valid_q  <= 1'b1;
						rsp_ok_q     <= res_ok_q;
						rsp_chosen_q <= res_chosen_q;
						rsp_status_q <= res_status_q;
						rsp_count_q  <= res_count_q;
						rsp_mask_q   <= mask_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.ok          = rsp_ok_q;
	assign rsp.chosen_unit = rsp_chosen_q;
	assign rsp.unit_status = rsp_status_q;
	assign rsp.unit_count  = rsp_count_q;
	assign rsp.avail_mask  = rsp_mask_q;

endmodule

// ===== verif/replica_round_robin_selector_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// replica_round_robin_selector_checker: request/result scoreboard
// Watches both channels, keeps its own copy of the replica lists and
// round-robin pointers, predicts the result of every accepted request and
// compares each accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
module replica_round_robin_selector_checker
	import rrs_pkg::*;
#(
	parameter int unsigned NUM_MODELS   = NUM_MODELS_DEF,
	parameter int unsigned MAX_REPLICAS = MAX_REPLICAS_DEF,
	parameter int unsigned NUM_UNITS    = NUM_UNITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	rrs_req_if   req,
	rrs_rsp_if   rsp,
	output int   fail_count,
	output int   pending
);

	typedef struct packed {
		logic                ok;
		logic [UNIT_W-1:0]   chosen_unit;
		logic [STATUS_W-1:0] unit_status;
		logic [COUNT_W-1:0]  unit_count;
		logic [MASK_W-1:0]   avail_mask;
	} selector_result_t;

	// Shadow copy of the per-model replica lists
	logic [UNIT_W-1:0]   shadow_unit   [NUM_MODELS][MAX_REPLICAS];
	logic [STATUS_W-1:0] shadow_status [NUM_MODELS][MAX_REPLICAS];
	int unsigned         shadow_len    [NUM_MODELS];
	int unsigned         shadow_ptr    [NUM_MODELS];

	selector_result_t awaited_results[$];
	selector_result_t got;
	selector_result_t want;
	selector_result_t predicted;
	int               mismatch_count;

	// Position of a unit in a model's list, -1 when absent
	function automatic int locate_unit(int unsigned m, logic [UNIT_W-1:0] u);
		for (int i = 0; i < int'(shadow_len[m]); i++) begin
			if (shadow_unit[m][i] == u)
				return i;
		end
		return -1;
	endfunction

	function automatic logic [MASK_W-1:0] available_units(int unsigned m);
		logic [MASK_W-1:0] mask;
		mask = '0;
		for (int i = 0; i < int'(shadow_len[m]); i++) begin
			if (shadow_status[m][i] == STATUS_AVAIL)
				mask |= MASK_ONE << shadow_unit[m][i];
		end
		return mask;
	endfunction

	// Apply one request to the shadow lists and work out its result
	function automatic selector_result_t apply_request(logic [KIND_W-1:0] kind,
		logic [MODEL_W-1:0] model_id, logic [UNIT_W-1:0] unit_id,
		logic [STATUS_W-1:0] new_status);
		selector_result_t r;
		int unsigned      m;
		int unsigned      n;
		int unsigned      idx;
		int               pos;
		r = '0;
		m = model_id;
		if (m >= NUM_MODELS)
			return r;
		n   = shadow_len[m];
		pos = locate_unit(m, unit_id);
		case (kind)
			KIND_ADD: begin
				if (unit_id < NUM_UNITS && n < MAX_REPLICAS && pos < 0) begin
					shadow_unit[m][n]   = unit_id;
					shadow_status[m][n] = STATUS_AVAIL;
					shadow_len[m]       = n + 1;
					r.ok                = 1'b1;
				end
			end
			KIND_REMOVE: begin
				// close the gap and pull the pointer back if it fell off the end
				if (pos >= 0) begin
					for (int i = pos; i + 1 < int'(n); i++) begin
						shadow_unit[m][i]   = shadow_unit[m][i+1];
						shadow_status[m][i] = shadow_status[m][i+1];
					end
					shadow_len[m] = n - 1;
					if (shadow_ptr[m] >= n - 1)
						shadow_ptr[m] = 0;
					r.ok = 1'b1;
				end
			end
			KIND_SET: begin
				if (pos >= 0) begin
					shadow_status[m][pos] = new_status;
					r.ok                  = 1'b1;
				end
			end
			KIND_GET: begin
				if (pos >= 0) begin
					r.unit_status = shadow_status[m][pos];
					r.ok          = 1'b1;
				end
			end
			KIND_SELECT: begin
				// scan from the pointer, wrapping, for the first available entry
				for (int unsigned a = 0; a < n && !r.ok; a++) begin
					idx = (shadow_ptr[m] + a) % n;
					if (shadow_status[m][idx] == STATUS_AVAIL) begin
						r.chosen_unit = shadow_unit[m][idx];
						shadow_ptr[m] = (idx + 1) % n;
						r.ok          = 1'b1;
					end
				end
			end
			KIND_QUERY: r.ok = 1'b1;
			default: ;
		endcase
		r.unit_count = COUNT_W'(shadow_len[m]);
		r.avail_mask = available_units(m);
		return r;
	endfunction

	function automatic void report_result(string what, selector_result_t w,
		selector_result_t g);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%0t %s: expected ok=%0d unit=%0d status=%0d count=%0d mask=%h",
				$realtime, what, w.ok, w.chosen_unit, w.unit_status, w.unit_count,
				w.avail_mask);
			$display("    got ok=%0d unit=%0d status=%0d count=%0d mask=%h",
				g.ok, g.chosen_unit, g.unit_status, g.unit_count, g.avail_mask);
		end
	endfunction

	// Check results first, then record the request taken at the same edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int m = 0; m < NUM_MODELS; m++) begin
				shadow_len[m] = 0;
				shadow_ptr[m] = 0;
			end
			awaited_results.delete();
			mismatch_count = 0;
			fail_count     = 0;
			pending        = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				got = '{rsp.ok, rsp.chosen_unit, rsp.unit_status, rsp.unit_count,
					rsp.avail_mask};
				if (awaited_results.size() == 0) begin
					fail_count++;
					report_result("unexpected result", '0, got);
				end else begin
					want = awaited_results.pop_front();
					if (got.ok !== want.ok || got.chosen_unit !== want.chosen_unit ||
						got.unit_status !== want.unit_status ||
						got.unit_count !== want.unit_count ||
						got.avail_mask !== want.avail_mask) begin
						fail_count++;
						report_result("result mismatch", want, got);
					end
				end
			end
			if (req.valid && req.ready) begin
				predicted = apply_request(req.kind, req.model_id, req.unit_id,
					req.new_status);
				awaited_results = {awaited_results, predicted};
			end
			pending = awaited_results.size();
		end
	end

endmodule

// ===== verif/replica_round_robin_selector_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// replica_round_robin_selector_tb: testbench top of the replica selector
// Drives directed and random request traffic with bursty valid and a
// stalling receiver; a checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module replica_round_robin_selector_tb;
	import rrs_pkg::*;

	localparam int unsigned       RANDOM_ITEMS     = 600;
	localparam int unsigned       CYCLE_LIMIT      = 300000;
	localparam int unsigned       DRAIN_CYCLES     = 40;
	// request kinds the block does not define
	localparam logic [KIND_W-1:0] KIND_RESERVED_LO = 3'd6;
	localparam logic [KIND_W-1:0] KIND_RESERVED_HI = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	int          fail_count;
	int          pending;
	int unsigned cycle_count = 0;
	int unsigned burst_left = 0;
	int unsigned rx_left = 0;
	int unsigned rx_mode = 0;
	int unsigned rx_phase = 0;

	rrs_req_if req_ch ();
	rrs_rsp_if rsp_ch ();

	replica_round_robin_selector u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	replica_round_robin_selector_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Receiver: switch between always ready, light, heavy and periodic stalls
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(20, 200);
		end
		rx_left--;
		rx_phase++;
		case (rx_mode)
			0:       rsp_ch.ready = 1'b1;
			1:       rsp_ch.ready = ($urandom_range(0, 3) != 0);
			2:       rsp_ch.ready = ($urandom_range(0, 3) == 0);
			default: rsp_ch.ready = (rx_phase % 5 != 0);
		endcase
	end

	// Send one request transaction; valid stays high within a burst
	task automatic send_request(logic [KIND_W-1:0] kind, logic [MODEL_W-1:0] model_id,
		logic [UNIT_W-1:0] unit_id, logic [STATUS_W-1:0] new_status);
		int unsigned gap;
		if (burst_left == 0) begin
			req_ch.valid = 1'b0;
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			repeat (gap) @(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 8);
		end
		req_ch.valid      = 1'b1;
		req_ch.kind       = kind;
		req_ch.model_id   = model_id;
		req_ch.unit_id    = unit_id;
		req_ch.new_status = new_status;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
		burst_left--;
	endtask

	// Hold off the sender until every result is back
	task automatic wait_all_results();
		req_ch.valid = 1'b0;
		burst_left   = 0;
		while (pending != 0) @(negedge clk);
	endtask

	// Weighted random request: adds and selects weigh most to keep lists busy
	task automatic send_random_request();
		int unsigned       pick;
		logic [KIND_W-1:0] kind;
		logic [STATUS_W-1:0] status;
		pick = $urandom_range(0, 99);
		if (pick < 25)      kind = KIND_ADD;
		else if (pick < 37) kind = KIND_REMOVE;
		else if (pick < 52) kind = KIND_SET;
		else if (pick < 64) kind = KIND_GET;
		else if (pick < 86) kind = KIND_SELECT;
		else if (pick < 96) kind = KIND_QUERY;
		else if (pick < 98) kind = KIND_RESERVED_LO;
		else                kind = KIND_RESERVED_HI;
		// lean toward available so selects keep finding units
		status = ($urandom_range(0, 1) == 0) ? STATUS_AVAIL : STATUS_W'($urandom_range(0, 3));
		send_request(kind, MODEL_W'($urandom_range(0, 7)), UNIT_W'($urandom_range(0, 15)),
			status);
	endtask

	initial begin
		req_ch.valid      = 1'b0;
		req_ch.kind       = KIND_ADD;
		req_ch.model_id   = '0;
		req_ch.unit_id    = '0;
		req_ch.new_status = '0;
		rsp_ch.ready      = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Empty list: select, get, set and remove all miss
		send_request(KIND_SELECT, 3'd0, 4'd0, 2'd0);
		send_request(KIND_GET, 3'd0, 4'd5, 2'd0);
		send_request(KIND_SET, 3'd0, 4'd5, 2'd3);
		send_request(KIND_REMOVE, 3'd0, 4'd5, 2'd0);
		// Lowest and highest unit, then a duplicate add
		send_request(KIND_ADD, 3'd0, 4'd0, 2'd0);
		send_request(KIND_ADD, 3'd0, 4'd15, 2'd0);
		send_request(KIND_ADD, 3'd0, 4'd0, 2'd0);
		send_request(KIND_SET, 3'd0, 4'd15, 2'd3);
		send_request(KIND_GET, 3'd0, 4'd15, 2'd0);
		// Selects skip the unavailable unit and wrap
		send_request(KIND_SELECT, 3'd0, 4'd0, 2'd0);
		send_request(KIND_SELECT, 3'd0, 4'd0, 2'd0);
		// No available unit left
		send_request(KIND_SET, 3'd0, 4'd0, 2'd2);
		send_request(KIND_SELECT, 3'd0, 4'd0, 2'd0);
		send_request(KIND_RESERVED_LO, 3'd0, 4'd0, 2'd0);
		send_request(KIND_RESERVED_HI, 3'd0, 4'd0, 2'd0);
		// Fill the last model and overflow it
		for (int u = 8; u < 16; u++)
			send_request(KIND_ADD, 3'd7, UNIT_W'(u), 2'd0);
		send_request(KIND_ADD, 3'd7, 4'd1, 2'd0);
		send_request(KIND_QUERY, 3'd7, 4'd0, 2'd0);
		// Remove pulls a pointer at the end back to zero
		send_request(KIND_ADD, 3'd1, 4'd3, 2'd0);
		send_request(KIND_ADD, 3'd1, 4'd4, 2'd0);
		send_request(KIND_SELECT, 3'd1, 4'd0, 2'd0);
		send_request(KIND_REMOVE, 3'd1, 4'd3, 2'd0);
		send_request(KIND_SELECT, 3'd1, 4'd0, 2'd0);
		wait_all_results();

		// Random traffic with a full drain halfway
		for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 2)
				wait_all_results();
			send_random_request();
		end
		wait_all_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== replica_round_robin_selector.f =====
sv/rrs_pkg.sv
sv/rrs_req_if.sv
sv/rrs_rsp_if.sv
sv/rrs_entry_ram.sv
sv/replica_round_robin_selector.sv
verif/replica_round_robin_selector_checker.sv
verif/replica_round_robin_selector_tb.sv
